/* rtl/pcbw_pkg.sv */
// ---------------------------------------------------------------------------
// pcbw_pkg
// Shared types, codes and pixel helpers for the pixel convert/blend writer.
// ---------------------------------------------------------------------------
package pcbw_pkg;

  // full width of y*stride+x before the range check
  localparam int unsigned ADDR_W = 26;
  localparam int unsigned PROD_W = 25;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);

  localparam logic [0:0] CFG_DEST_FORMAT = 1'b0;
  localparam logic [0:0] CFG_STRIDE      = 1'b1;

  localparam logic [12:0] STRIDE_RESET = 13'd1024;

  typedef enum logic [2:0] {
    FMT_ARGB = 3'd0,
    FMT_RGB  = 3'd1,
    FMT_RGBA = 3'd2,
    FMT_ABGR = 3'd3,
    FMT_BGR  = 3'd4
  } fmt_t;

  typedef enum logic [0:0] {
    OP_SET   = 1'b0,
    OP_BLEND = 1'b1
  } op_t;

  // what the back end does with a queued item
  typedef enum logic [1:0] {
    K_SKIP  = 2'd0,
    K_SET   = 2'd1,
    K_BLEND = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_READ = 2'd1,
    B_MUL  = 2'd2,
    B_OUT  = 2'd3
  } back_state_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pix_ch_t;

  // data holds the final pixel for a set, the source channels for a blend
  typedef struct packed {
    kind_t             kind;
    logic              oor;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       data;
  } entry_t;

  // unknown codes fall back to argb
  function automatic pix_ch_t unpack_pix(input logic [2:0] fmt, input logic [31:0] p);
    pix_ch_t c;
    case (fmt)
      FMT_RGB:  c = '{a: 8'hFF,    r: p[23:16], g: p[15:8],  b: p[7:0]};
      FMT_RGBA: c = '{a: p[7:0],   r: p[31:24], g: p[23:16], b: p[15:8]};
      FMT_ABGR: c = '{a: p[31:24], r: p[7:0],   g: p[15:8],  b: p[23:16]};
      FMT_BGR:  c = '{a: 8'hFF,    r: p[7:0],   g: p[15:8],  b: p[23:16]};
      default:  c = '{a: p[31:24], r: p[23:16], g: p[15:8],  b: p[7:0]};
    endcase
    return c;
  endfunction

  function automatic logic [31:0] pack_pix(input logic [2:0] fmt, input pix_ch_t c);
    logic [31:0] p;
    case (fmt)
      FMT_RGB:  p = {8'h00, c.r, c.g, c.b};
      FMT_RGBA: p = {c.r, c.g, c.b, c.a};
      FMT_ABGR: p = {c.a, c.b, c.g, c.r};
      FMT_BGR:  p = {8'h00, c.b, c.g, c.r};
      default:  p = {c.a, c.r, c.g, c.b};
    endcase
    return p;
  endfunction

  // exact v/255 while the quotient fits in 8 bits (v below 65280)
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] t;
    t = 17'(v) + 17'd1 + 17'(v[15:8]);
    return t[15:8];
  endfunction

endpackage

/* rtl/pcbw_queue.sv */
// ---------------------------------------------------------------------------
// pcbw_queue
// Short fifo of classified items between front and back end.
// ---------------------------------------------------------------------------
module pcbw_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  pcbw_pkg::entry_t push_entry,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output pcbw_pkg::entry_t head
);
  import pcbw_pkg::*;

  entry_t               slots [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_PTR_W:0]     count;

  assign full      = (count == (Q_PTR_W+1)'(Q_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

/* rtl/pcbw_front.sv */
// ---------------------------------------------------------------------------
// pcbw_front
// Takes items, forms the address, range checks and converts set pixels.
// ---------------------------------------------------------------------------
module pcbw_front #(
  parameter int unsigned FB_PIXELS = 65536
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic             opcode,
  input  logic [11:0]      x_coord,
  input  logic [11:0]      y_coord,
  input  logic [2:0]       src_format,
  input  logic [31:0]      src_pixel,
  input  logic [2:0]       dest_format,
  input  logic [12:0]      stride_pixels,
  input  logic             q_full,
  output logic             hold,
  output logic             push,
  output pcbw_pkg::entry_t push_entry
);
  import pcbw_pkg::*;

  logic              a_valid;
  logic              a_op;
  logic [11:0]       a_x;
  logic [2:0]        a_sfmt;
  logic [31:0]       a_spix;
  logic [PROD_W-1:0] a_prod;

  logic [ADDR_W-1:0] addr;
  logic              oor;
  pix_ch_t           s_ch;
  logic [31:0]       set_val;

  assign push = a_valid && !q_full;
  assign hold = a_valid && q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (take) begin
      a_valid <= 1'b1;
    end else if (push) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_op   <= opcode;
      a_x    <= x_coord;
      a_sfmt <= src_format;
      a_spix <= src_pixel;
      a_prod <= PROD_W'(y_coord) * PROD_W'(stride_pixels);
    end
  end

  always_comb begin
    addr    = ADDR_W'(a_prod) + ADDR_W'(a_x);
    oor     = (addr >= ADDR_W'(FB_PIXELS));
    s_ch    = unpack_pix(a_sfmt, a_spix);
    // matching codes copy raw, even for a no-alpha format
    set_val = (a_sfmt == dest_format) ? a_spix : pack_pix(dest_format, s_ch);

    push_entry.addr = addr;
    push_entry.oor  = oor;
    if (oor) begin
      push_entry.kind = K_SKIP;
      push_entry.data = '0;
    end else if (a_op == OP_SET) begin
      push_entry.kind = K_SET;
      push_entry.data = set_val;
    end else if (s_ch.a == 8'h00) begin
      push_entry.kind = K_SKIP;
      push_entry.data = '0;
    end else begin
      push_entry.kind = K_BLEND;
      push_entry.data = s_ch;
    end
  end

endmodule

/* rtl/pcbw_back.sv */
// ---------------------------------------------------------------------------
// pcbw_back
// Owns the pixel store: clearing pass, read-modify-write blend and results.
// ---------------------------------------------------------------------------
module pcbw_back #(
  parameter int unsigned FB_PIXELS = 65536
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  pcbw_pkg::entry_t q_head,
  input  logic [2:0]       dest_format,
  output logic             q_pop,
  output logic             clearing,
  output logic             done,
  output logic [15:0]      write_address,
  output logic [31:0]      pixel_written,
  output logic             did_write,
  output logic             out_of_range
);
  import pcbw_pkg::*;

  localparam int unsigned AW = $clog2(FB_PIXELS);

  logic [31:0] mem [FB_PIXELS];

  back_state_t state;
  back_state_t state_next;
  entry_t      cur;
  logic [31:0] rd_data;
  logic [AW-1:0] clr_idx;

  logic [15:0] ps [4];
  logic [15:0] pd [4];

  pix_ch_t     s_ch;
  pix_ch_t     d_ch;
  logic [7:0]  s_arr [4];
  logic [7:0]  d_arr [4];
  logic [7:0]  ia;
  logic [7:0]  o_arr [4];
  logic [31:0] blend_val;
  logic [31:0] out_val;
  logic        out_we;
  logic        mem_we;
  logic [AW-1:0] mem_idx;
  logic [31:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    case (state)
      B_IDLE: begin
        if (!clearing && q_valid) begin
          q_pop      = 1'b1;
          state_next = (q_head.kind == K_BLEND) ? B_READ : B_OUT;
        end
      end
      B_READ:  state_next = B_MUL;
      B_MUL:   state_next = B_OUT;
      B_OUT:   state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
  end

  // channel order r, g, b, a
  always_comb begin
    s_ch     = cur.data;
    d_ch     = unpack_pix(dest_format, rd_data);
    ia       = 8'hFF - s_ch.a;
    s_arr[0] = s_ch.r;
    s_arr[1] = s_ch.g;
    s_arr[2] = s_ch.b;
    s_arr[3] = 8'hFF;
    d_arr[0] = d_ch.r;
    d_arr[1] = d_ch.g;
    d_arr[2] = d_ch.b;
    d_arr[3] = d_ch.a;
  end

  always_ff @(posedge clk) begin
    if (state == B_MUL) begin
      for (int k = 0; k < 4; k++) begin
        ps[k] <= s_arr[k] * s_ch.a;
        pd[k] <= d_arr[k] * ia;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      o_arr[k] = div255(ps[k] + pd[k] + 16'd127);
    end
    // a no-alpha destination drops the alpha lane in the pack
    blend_val = pack_pix(dest_format,
                         '{a: o_arr[3], r: o_arr[0], g: o_arr[1], b: o_arr[2]});
    case (cur.kind)
      K_SET: begin
        out_we  = 1'b1;
        out_val = cur.data;
      end
      K_BLEND: begin
        out_we  = 1'b1;
        out_val = blend_val;
      end
      default: begin
        out_we  = 1'b0;
        out_val = '0;
      end
    endcase
  end

  // zero every entry once after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == AW'(FB_PIXELS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_comb begin
    if (clearing) begin
      mem_we    = 1'b1;
      mem_idx   = clr_idx;
      mem_wdata = '0;
    end else begin
      mem_we    = (state == B_OUT) && out_we;
      mem_idx   = cur.addr[AW-1:0];
      mem_wdata = out_val;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_idx] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[cur.addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == B_OUT);
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_OUT) begin
      write_address <= cur.addr[15:0];
      pixel_written <= out_val;
      did_write     <= out_we;
      out_of_range  <= cur.oor;
    end
  end

endmodule

/* rtl/pixel_convert_blend_writer.sv */
// ---------------------------------------------------------------------------
// pixel_convert_blend_writer
// Pixel writer with format conversion and source-over blend into a store.
// ---------------------------------------------------------------------------
//  channel   signals                                         handshake
//  item in   opcode x_coord y_coord src_format src_pixel     start, busy
//  result    write_address pixel_written did_write           done strobe
//            out_of_range
//  config    cfg_index cfg_data                              cfg_we
//
//  the front end registers y*stride, then classifies into a two entry queue;
//  the back end sequencer sets the rate: a set or a skipped item passes the
//  idle and output states, a blend also the read and multiply states (store
//  read, multiply, divide and write); it pops an item only while idle
//  after reset the store is cleared one entry a cycle with busy high; busy
//  also rises when the queue is full and the front stage holds
//  results are a one-cycle strobe, the receiver cannot hold them off
// ---------------------------------------------------------------------------
module pixel_convert_blend_writer #(
  parameter int unsigned FB_PIXELS = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        opcode,
  input  logic [11:0] x_coord,
  input  logic [11:0] y_coord,
  input  logic [2:0]  src_format,
  input  logic [31:0] src_pixel,
  output logic        done,
  output logic [15:0] write_address,
  output logic [31:0] pixel_written,
  output logic        did_write,
  output logic        out_of_range,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  import pcbw_pkg::*;

  logic [2:0]  dest_format;
  logic [12:0] stride_pixels;

  logic   take;
  logic   hold;
  logic   push;
  entry_t push_entry;
  logic   q_full;
  logic   q_valid;
  entry_t q_head;
  logic   q_pop;
  logic   clearing;

  assign busy = clearing || hold;
  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_format   <= FMT_ARGB;
      stride_pixels <= STRIDE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEST_FORMAT: dest_format   <= cfg_data[2:0];
        CFG_STRIDE:      stride_pixels <= cfg_data;
        default:         ;
      endcase
    end
  end

  pcbw_front #(
    .FB_PIXELS(FB_PIXELS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .opcode       (opcode),
    .x_coord      (x_coord),
    .y_coord      (y_coord),
    .src_format   (src_format),
    .src_pixel    (src_pixel),
    .dest_format  (dest_format),
    .stride_pixels(stride_pixels),
    .q_full       (q_full),
    .hold         (hold),
    .push         (push),
    .push_entry   (push_entry)
  );

  pcbw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  pcbw_back #(
    .FB_PIXELS(FB_PIXELS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .dest_format  (dest_format),
    .q_pop        (q_pop),
    .clearing     (clearing),
    .done         (done),
    .write_address(write_address),
    .pixel_written(pixel_written),
    .did_write    (did_write),
    .out_of_range (out_of_range)
  );

endmodule

/* rtl/pcbw_check.sv */
// ---------------------------------------------------------------------------
// pcbw_check
// Port-level checks for the pixel writer, bound to the top level.
// ---------------------------------------------------------------------------
module pcbw_check (
  input logic        clk,
  input logic        rst,
  input logic        busy,
  input logic        done,
  input logic [31:0] pixel_written,
  input logic        did_write,
  input logic        out_of_range
);

  // store clear keeps the block busy straight after reset
  a_busy_after_rst: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low after reset");

  a_no_done_after_rst: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  a_oor_no_write: assert property (@(posedge clk) disable iff (rst)
    done && out_of_range |-> !did_write)
    else $error("write reported for out of range address");

  a_zero_when_skipped: assert property (@(posedge clk) disable iff (rst)
    done && !did_write |-> pixel_written == 32'd0)
    else $error("non-zero pixel on a skipped transfer");

  // every item passes the idle and output states, so results never come back to back
  a_done_spacing: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("results on consecutive cycles");

endmodule

bind pixel_convert_blend_writer pcbw_check u_pcbw_check (
  .clk          (clk),
  .rst          (rst),
  .busy         (busy),
  .done         (done),
  .pixel_written(pixel_written),
  .did_write    (did_write),
  .out_of_range (out_of_range)
);
